// ===== design/echo_state_reservoir_step_assert.svh =====
// ---------------------------------------------------------------------------
// echo state reservoir step assertion macros
// shared property wrappers, clocked on clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef ECHO_STATE_RESERVOIR_STEP_ASSERT_SVH
`define ECHO_STATE_RESERVOIR_STEP_ASSERT_SVH

// same-cycle implication
`define ESR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/esr_pkg.sv =====
// ---------------------------------------------------------------------------
// esr_pkg
// sizes, codes, types and fixed-point helpers of the reservoir step block
// ---------------------------------------------------------------------------
package esr_pkg;

  localparam int MAX_NEURONS  = 256;
  localparam int MAX_INPUTS   = 16;
  localparam int MAX_OUTPUTS  = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int OUT_LIMIT    = (MAX_OUTPUTS < RESULT_LIMIT) ? MAX_OUTPUTS : RESULT_LIMIT;

  localparam int ROW_SPAN   = 1 + MAX_INPUTS + MAX_NEURONS;
  localparam int WIN_SPAN   = MAX_INPUTS + 1;
  localparam int W_DEPTH    = MAX_NEURONS * MAX_NEURONS;
  localparam int WIN_DEPTH  = MAX_NEURONS * WIN_SPAN;
  localparam int WOUT_DEPTH = MAX_OUTPUTS * ROW_SPAN;

  localparam int W_AW    = $clog2(W_DEPTH);
  localparam int WIN_AW  = $clog2(WIN_DEPTH);
  localparam int WOUT_AW = $clog2(WOUT_DEPTH);
  localparam int N_AW    = $clog2(MAX_NEURONS);
  localparam int D_AW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int TERM_W  = $clog2(ROW_SPAN);
  localparam int NCNT_W  = $clog2(MAX_NEURONS + 1);
  localparam int DCNT_W  = $clog2(MAX_INPUTS + 1);
  localparam int OCNT_W  = $clog2(OUT_LIMIT + 1);

  localparam int DATA_W    = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 48;
  localparam int OP_W      = 3;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 9;
  localparam int OIDX_W    = 4;
  localparam int LEAK_W    = 16;
  localparam int NREG_W    = 9;
  localparam int DREG_W    = 5;
  localparam int OREG_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int P1_W      = 34;
  localparam int BL_W      = 36;

  localparam int DRAIN_CYCLES = 2;
  localparam int READOUT_SHIFT = 11;
  localparam int BLEND_SHIFT   = 16;

  localparam logic signed [DATA_W-1:0] BIAS_ONE = 16'sd8192;

  localparam logic [13:0] TANH_PTS [0:32] = '{
    14'd0,    14'd1019, 14'd2006, 14'd2936, 14'd3786, 14'd4545, 14'd5203, 14'd5766,
    14'd6239, 14'd6630, 14'd6949, 14'd7208, 14'd7415, 14'd7580, 14'd7712, 14'd7815,
    14'd7897, 14'd7961, 14'd8012, 14'd8051, 14'd8082, 14'd8107, 14'd8125, 14'd8140,
    14'd8151, 14'd8160, 14'd8167, 14'd8173, 14'd8177, 14'd8180, 14'd8183, 14'd8185,
    14'd8186
  };

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_W    = 3'd0,
    OP_WRITE_WIN  = 3'd1,
    OP_WRITE_WOUT = 3'd2,
    OP_SAMPLE     = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAK    = 2'd0,
    CFG_NEURONS = 2'd1,
    CFG_INPUTS  = 2'd2,
    CFG_OUTPUTS = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_DRAIN,
    ST_TANH,
    ST_BLEND1,
    ST_BLEND2,
    ST_WRITE,
    ST_PREFETCH,
    ST_COPY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic clr;
    logic valid;
  } mac_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat_round(
    input logic signed [ACC_W-1:0] v,
    input int unsigned sh
  );
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] r;
    logic signed [DATA_W-1:0] y;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r = (mag + (ACC_W'(1) << (sh - 1))) >> sh;
    if (v[ACC_W-1]) begin
      y = (r > ACC_W'(32768)) ? 16'sh8000 : DATA_W'(ACC_W'(0) - r);
    end else begin
      y = (r > ACC_W'(32767)) ? 16'sh7fff : DATA_W'(r);
    end
    return y;
  endfunction

  function automatic logic signed [DATA_W-1:0] tanh_fixed(
    input logic signed [ACC_W-1:0] acc
  );
    logic [ACC_W-1:0] mag;
    logic [4:0] seg;
    logic [6:0] frac;
    logic [13:0] lo;
    logic [13:0] hi;
    logic [17:0] step;
    logic [13:0] y;
    mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    seg  = mag[25:21];
    frac = mag[20:14];
    lo   = TANH_PTS[seg];
    hi   = TANH_PTS[6'(seg) + 6'd1];
    step = 18'(18'(hi - lo) * 18'(frac) + 18'd64);
    y    = lo + 14'(step >> 7);
    if (|mag[ACC_W-1:26]) begin
      y = TANH_PTS[32];
    end
    return acc[ACC_W-1] ? DATA_W'(16'd0 - 16'(y)) : DATA_W'(y);
  endfunction

endpackage

// ===== design/esr_ram.sv =====
// ---------------------------------------------------------------------------
// esr_ram
// generic simple dual-port ram, one write port, registered read
// ---------------------------------------------------------------------------
module esr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/esr_cell.sv =====
// ---------------------------------------------------------------------------
// esr_cell
// one neuron state cell of the rotating state chain
// ---------------------------------------------------------------------------
module esr_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  esr_pkg::cell_ctl_t                     ctl,
  input  logic signed [esr_pkg::DATA_W-1:0]      d,
  output logic signed [esr_pkg::DATA_W-1:0]      q
);

  logic signed [esr_pkg::DATA_W-1:0] x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
    end else if (ctl.clear) begin
      x_r <= '0;
    end else if (ctl.shift) begin
      x_r <= d;
    end
  end

  assign q = x_r;

endmodule

// ===== design/esr_mac.sv =====
// ---------------------------------------------------------------------------
// esr_mac
// pipelined multiply and saturating 48-bit accumulate
// ---------------------------------------------------------------------------
module esr_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  esr_pkg::mac_ctl_t                     ctl,
  input  logic signed [esr_pkg::DATA_W-1:0]     a,
  input  logic signed [esr_pkg::DATA_W-1:0]     b,
  output logic signed [esr_pkg::ACC_W-1:0]      acc
);

  logic signed [esr_pkg::PROD_W-1:0] prod_r;
  logic                              pv_r;
  logic signed [esr_pkg::ACC_W-1:0]  acc_r;
  logic signed [esr_pkg::ACC_W:0]    sum;
  logic signed [esr_pkg::ACC_W-1:0]  acc_nxt;

  assign sum = (esr_pkg::ACC_W + 1)'(acc_r) + (esr_pkg::ACC_W + 1)'(prod_r);

  always_comb begin
    if (sum[esr_pkg::ACC_W] != sum[esr_pkg::ACC_W-1]) begin
      acc_nxt = sum[esr_pkg::ACC_W] ? {1'b1, {(esr_pkg::ACC_W-1){1'b0}}}
                                    : {1'b0, {(esr_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = sum[esr_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== design/echo_state_reservoir_step.sv =====
// ---------------------------------------------------------------------------
// echo_state_reservoir_step
// leaky echo state network inference with one shared mac and a rotating
// chain of neuron state cells
//
//   channel  handshake          payload
//   in       start / busy       operation, row, column, weight, sample, last
//   out      out_valid strobe   output index, output value, last output
//   cfg      cfg_we             cfg_index, cfg_data
//
// writes, clears and non-last samples are taken without leaving idle
// a step is paced by the single mac walking each weight row
// reset is synchronous, clears the neuron state and counters and sets the config to its defaults
// each result strobe lasts one cycle and cannot be held off
// ---------------------------------------------------------------------------
`include "echo_state_reservoir_step_assert.svh"

module echo_state_reservoir_step (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic [esr_pkg::OP_W-1:0]                   in_operation,
  input  logic [esr_pkg::ROW_W-1:0]                  in_row_index,
  input  logic [esr_pkg::COL_W-1:0]                  in_column_index,
  input  logic signed [esr_pkg::DATA_W-1:0]          in_weight_value,
  input  logic signed [esr_pkg::DATA_W-1:0]          in_sample_value,
  input  logic                                       in_last_element,
  output logic                                       out_valid,
  output logic [esr_pkg::OIDX_W-1:0]                 out_output_index,
  output logic signed [esr_pkg::DATA_W-1:0]          out_output_value,
  output logic                                       out_last_output,
  input  logic                                       cfg_we,
  input  logic [esr_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [esr_pkg::CFG_W-1:0]                  cfg_data
);

  esr_pkg::state_t state_r;
  esr_pkg::state_t state_nxt;

  logic [esr_pkg::TERM_W-1:0]  term_r;
  logic [1:0]                  drain_r;
  logic [esr_pkg::N_AW-1:0]    row_r;
  logic                        rd_r;
  logic [esr_pkg::W_AW-1:0]    w_base_r;
  logic [esr_pkg::WIN_AW-1:0]  win_base_r;
  logic [esr_pkg::WOUT_AW-1:0] wout_base_r;

  logic [esr_pkg::LEAK_W-1:0]  leak_r;
  logic [esr_pkg::NREG_W-1:0]  nreg_r;
  logic [esr_pkg::DREG_W-1:0]  dreg_r;
  logic [esr_pkg::OREG_W-1:0]  oreg_r;
  logic [esr_pkg::NCNT_W-1:0]  n_use;
  logic [esr_pkg::DCNT_W-1:0]  d_use;
  logic [esr_pkg::OCNT_W-1:0]  o_use;

  logic [esr_pkg::DCNT_W-1:0]         count_r;
  logic signed [esr_pkg::DATA_W-1:0]  buf_r [esr_pkg::MAX_INPUTS];

  logic signed [esr_pkg::DATA_W-1:0]  b1_r;
  logic                               v1_r;
  logic                               st1_r;
  logic signed [esr_pkg::DATA_W-1:0]  xold_r;
  logic signed [esr_pkg::DATA_W-1:0]  t_r;
  logic signed [esr_pkg::P1_W-1:0]    p1_r;
  logic signed [esr_pkg::BL_W-1:0]    bl_r;

  logic                               out_valid_r;
  logic [esr_pkg::OIDX_W-1:0]         out_index_r;
  logic signed [esr_pkg::DATA_W-1:0]  out_value_r;
  logic                               out_last_r;

  logic accept;
  logic op_w;
  logic op_win;
  logic op_wout;
  logic op_sample;
  logic op_clear;
  logic is_bias;
  logic is_in;
  logic is_st;
  logic [esr_pkg::D_AW-1:0] in_j;
  logic [esr_pkg::N_AW-1:0] st_j;
  logic issue_valid;
  logic signed [esr_pkg::DATA_W-1:0] b_issue;
  logic last_neuron;
  logic last_out;
  logic [esr_pkg::LEAK_W:0] one_minus;

  logic                          w_we;
  logic [esr_pkg::W_AW-1:0]      w_waddr;
  logic [esr_pkg::W_AW-1:0]      w_raddr;
  logic [esr_pkg::DATA_W-1:0]    w_q;
  logic                          win_we;
  logic [esr_pkg::WIN_AW-1:0]    win_waddr;
  logic [esr_pkg::WIN_AW-1:0]    win_raddr;
  logic [esr_pkg::DATA_W-1:0]    win_q;
  logic                          wout_we;
  logic [esr_pkg::WOUT_AW-1:0]   wout_waddr;
  logic [esr_pkg::WOUT_AW-1:0]   wout_raddr;
  logic [esr_pkg::DATA_W-1:0]    wout_q;
  logic                          nx_we;
  logic [esr_pkg::N_AW-1:0]      nx_raddr;
  logic [esr_pkg::DATA_W-1:0]    nx_wdata;
  logic [esr_pkg::DATA_W-1:0]    nx_q;

  esr_pkg::cell_ctl_t cell_ctl;
  esr_pkg::mac_ctl_t  mac_ctl;
  logic signed [esr_pkg::DATA_W-1:0] cell_q [esr_pkg::MAX_NEURONS];
  logic signed [esr_pkg::DATA_W-1:0] cell_d [esr_pkg::MAX_NEURONS];
  logic signed [esr_pkg::DATA_W-1:0] head;
  logic signed [esr_pkg::DATA_W-1:0] insert;
  logic signed [esr_pkg::DATA_W-1:0] mac_a;
  logic signed [esr_pkg::ACC_W-1:0]  acc;

  // decode
  assign accept    = start && !busy;
  assign op_w      = in_operation == esr_pkg::OP_WRITE_W;
  assign op_win    = in_operation == esr_pkg::OP_WRITE_WIN;
  assign op_wout   = in_operation == esr_pkg::OP_WRITE_WOUT;
  assign op_sample = in_operation == esr_pkg::OP_SAMPLE;
  assign op_clear  = in_operation == esr_pkg::OP_CLEAR;

  always_comb begin
    if (nreg_r == '0) begin
      n_use = esr_pkg::NCNT_W'(1);
    end else if (32'(nreg_r) > esr_pkg::MAX_NEURONS) begin
      n_use = esr_pkg::NCNT_W'(esr_pkg::MAX_NEURONS);
    end else begin
      n_use = esr_pkg::NCNT_W'(nreg_r);
    end
    if (dreg_r == '0) begin
      d_use = esr_pkg::DCNT_W'(1);
    end else if (32'(dreg_r) > esr_pkg::MAX_INPUTS) begin
      d_use = esr_pkg::DCNT_W'(esr_pkg::MAX_INPUTS);
    end else begin
      d_use = esr_pkg::DCNT_W'(dreg_r);
    end
    if (oreg_r == '0) begin
      o_use = esr_pkg::OCNT_W'(1);
    end else if (32'(oreg_r) > esr_pkg::OUT_LIMIT) begin
      o_use = esr_pkg::OCNT_W'(esr_pkg::OUT_LIMIT);
    end else begin
      o_use = esr_pkg::OCNT_W'(oreg_r);
    end
  end

  // term decode
  assign is_bias = term_r == '0;
  assign is_in   = (term_r != '0) && (32'(term_r) <= esr_pkg::MAX_INPUTS);
  assign is_st   = 32'(term_r) > esr_pkg::MAX_INPUTS;
  assign in_j    = esr_pkg::D_AW'(term_r - esr_pkg::TERM_W'(1));
  assign st_j    = esr_pkg::N_AW'(term_r - esr_pkg::TERM_W'(esr_pkg::MAX_INPUTS + 1));
  assign head    = cell_q[0];

  always_comb begin
    if (is_bias) begin
      b_issue = esr_pkg::BIAS_ONE;
    end else if (is_in) begin
      b_issue = (esr_pkg::DCNT_W'(in_j) < count_r) ? buf_r[in_j] : '0;
    end else begin
      b_issue = head;
    end
  end

  assign last_neuron = esr_pkg::NCNT_W'(row_r) == n_use - esr_pkg::NCNT_W'(1);
  assign last_out    = esr_pkg::OCNT_W'(row_r) == o_use - esr_pkg::OCNT_W'(1);
  assign one_minus   = (esr_pkg::LEAK_W + 1)'(1 << esr_pkg::LEAK_W)
                     - (esr_pkg::LEAK_W + 1)'(leak_r);

  // weight write ports
  assign w_we = accept && op_w && (32'(in_row_index) < esr_pkg::MAX_NEURONS)
                && (32'(in_column_index) < esr_pkg::MAX_NEURONS);
  assign w_waddr = esr_pkg::W_AW'(32'(in_row_index) * esr_pkg::MAX_NEURONS
                                  + 32'(in_column_index));
  assign win_we = accept && op_win && (32'(in_row_index) < esr_pkg::MAX_NEURONS)
                  && (32'(in_column_index) < esr_pkg::WIN_SPAN);
  assign win_waddr = esr_pkg::WIN_AW'(32'(in_row_index) * esr_pkg::WIN_SPAN
                                      + 32'(in_column_index));
  assign wout_we = accept && op_wout && (32'(in_row_index) < esr_pkg::MAX_OUTPUTS)
                   && (32'(in_column_index) < esr_pkg::ROW_SPAN);
  assign wout_waddr = esr_pkg::WOUT_AW'(32'(in_row_index) * esr_pkg::ROW_SPAN
                                        + 32'(in_column_index));

  // read addresses
  assign w_raddr   = w_base_r + esr_pkg::W_AW'(st_j);
  assign win_raddr = win_base_r + esr_pkg::WIN_AW'(term_r);
  assign wout_raddr = is_st
    ? wout_base_r + esr_pkg::WOUT_AW'(1) + esr_pkg::WOUT_AW'(d_use) + esr_pkg::WOUT_AW'(st_j)
    : wout_base_r + esr_pkg::WOUT_AW'(term_r);
  assign nx_raddr = (state_r == esr_pkg::ST_COPY)
                  ? esr_pkg::N_AW'(term_r + esr_pkg::TERM_W'(1)) : '0;
  assign nx_wdata = esr_pkg::sat_round(esr_pkg::ACC_W'(bl_r), esr_pkg::BLEND_SHIFT);

  esr_ram #(.WIDTH(esr_pkg::DATA_W), .DEPTH(esr_pkg::W_DEPTH)) u_w_ram (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(in_weight_value),
    .raddr(w_raddr), .rdata(w_q)
  );

  esr_ram #(.WIDTH(esr_pkg::DATA_W), .DEPTH(esr_pkg::WIN_DEPTH)) u_win_ram (
    .clk, .we(win_we), .waddr(win_waddr), .wdata(in_weight_value),
    .raddr(win_raddr), .rdata(win_q)
  );

  esr_ram #(.WIDTH(esr_pkg::DATA_W), .DEPTH(esr_pkg::WOUT_DEPTH)) u_wout_ram (
    .clk, .we(wout_we), .waddr(wout_waddr), .wdata(in_weight_value),
    .raddr(wout_raddr), .rdata(wout_q)
  );

  esr_ram #(.WIDTH(esr_pkg::DATA_W), .DEPTH(esr_pkg::MAX_NEURONS)) u_nx_ram (
    .clk, .we(nx_we), .waddr(row_r), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_q)
  );

  // state chain
  assign insert = ((state_r == esr_pkg::ST_COPY) && (esr_pkg::NCNT_W'(term_r) < n_use))
                ? $signed(nx_q) : head;

  for (genvar k = 0; k < esr_pkg::MAX_NEURONS; k++) begin : g_cell
    if (k == esr_pkg::MAX_NEURONS - 1) begin : g_tail
      assign cell_d[k] = insert;
    end else begin : g_link
      assign cell_d[k] = cell_q[k+1];
    end
    esr_cell u_cell (
      .clk, .rst_n, .ctl(cell_ctl), .d(cell_d[k]), .q(cell_q[k])
    );
  end

  // mac
  assign mac_a = rd_r ? $signed(wout_q) : (st1_r ? $signed(w_q) : $signed(win_q));

  esr_mac u_mac (
    .clk, .rst_n, .ctl(mac_ctl), .a(mac_a), .b(b1_r), .acc(acc)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      esr_pkg::ST_IDLE: begin
        if (accept && op_sample && in_last_element) state_nxt = esr_pkg::ST_ROW;
      end
      esr_pkg::ST_ROW: begin
        if (32'(term_r) == esr_pkg::ROW_SPAN - 1) state_nxt = esr_pkg::ST_DRAIN;
      end
      esr_pkg::ST_DRAIN: begin
        if (32'(drain_r) == esr_pkg::DRAIN_CYCLES - 1) begin
          state_nxt = rd_r ? esr_pkg::ST_EMIT : esr_pkg::ST_TANH;
        end
      end
      esr_pkg::ST_TANH:     state_nxt = esr_pkg::ST_BLEND1;
      esr_pkg::ST_BLEND1:   state_nxt = esr_pkg::ST_BLEND2;
      esr_pkg::ST_BLEND2:   state_nxt = esr_pkg::ST_WRITE;
      esr_pkg::ST_WRITE: begin
        state_nxt = last_neuron ? esr_pkg::ST_PREFETCH : esr_pkg::ST_ROW;
      end
      esr_pkg::ST_PREFETCH: state_nxt = esr_pkg::ST_COPY;
      esr_pkg::ST_COPY: begin
        if (32'(term_r) == esr_pkg::MAX_NEURONS - 1) state_nxt = esr_pkg::ST_ROW;
      end
      esr_pkg::ST_EMIT: begin
        state_nxt = last_out ? esr_pkg::ST_IDLE : esr_pkg::ST_ROW;
      end
      default: state_nxt = esr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy           = state_r != esr_pkg::ST_IDLE;
    cell_ctl.shift = ((state_r == esr_pkg::ST_ROW) && is_st) || (state_r == esr_pkg::ST_COPY);
    cell_ctl.clear = accept && op_clear;
    mac_ctl.clr    = (state_r == esr_pkg::ST_ROW) && is_bias;
    mac_ctl.valid  = v1_r;
    nx_we          = state_r == esr_pkg::ST_WRITE;
    issue_valid    = (state_r == esr_pkg::ST_ROW)
                     && (is_bias
                         || (is_in && (esr_pkg::DCNT_W'(in_j) < d_use))
                         || (is_st && (esr_pkg::NCNT_W'(st_j) < n_use)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esr_pkg::ST_IDLE;
      term_r  <= '0;
      drain_r <= '0;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue_valid;
      if ((state_r == esr_pkg::ST_ROW) || (state_r == esr_pkg::ST_COPY)) begin
        term_r <= (state_nxt != state_r) ? '0 : term_r + esr_pkg::TERM_W'(1);
      end else begin
        term_r <= '0;
      end
      drain_r <= (state_r == esr_pkg::ST_DRAIN) ? drain_r + 2'd1 : 2'd0;
    end
  end

  // row walk
  always_ff @(posedge clk) begin
    if ((state_r == esr_pkg::ST_IDLE) && (state_nxt == esr_pkg::ST_ROW)) begin
      row_r      <= '0;
      rd_r       <= 1'b0;
      w_base_r   <= '0;
      win_base_r <= '0;
    end else if ((state_r == esr_pkg::ST_WRITE) && !last_neuron) begin
      row_r      <= row_r + esr_pkg::N_AW'(1);
      w_base_r   <= w_base_r + esr_pkg::W_AW'(esr_pkg::MAX_NEURONS);
      win_base_r <= win_base_r + esr_pkg::WIN_AW'(esr_pkg::WIN_SPAN);
    end else if ((state_r == esr_pkg::ST_COPY) && (state_nxt == esr_pkg::ST_ROW)) begin
      row_r       <= '0;
      rd_r        <= 1'b1;
      wout_base_r <= '0;
    end else if ((state_r == esr_pkg::ST_EMIT) && !last_out) begin
      row_r       <= row_r + esr_pkg::N_AW'(1);
      wout_base_r <= wout_base_r + esr_pkg::WOUT_AW'(esr_pkg::ROW_SPAN);
    end
  end

  // operand stage and post-processing
  always_ff @(posedge clk) begin
    b1_r  <= b_issue;
    st1_r <= is_st;
    if ((state_r == esr_pkg::ST_ROW) && is_st && !rd_r && (st_j == row_r)) begin
      xold_r <= head;
    end
    if (state_r == esr_pkg::ST_TANH) begin
      t_r <= esr_pkg::tanh_fixed(acc);
    end
    if (state_r == esr_pkg::ST_BLEND1) begin
      p1_r <= $signed({1'b0, one_minus}) * xold_r;
    end
    if (state_r == esr_pkg::ST_BLEND2) begin
      bl_r <= esr_pkg::BL_W'(p1_r) + esr_pkg::BL_W'($signed({1'b0, leak_r}) * t_r);
    end
  end

  // input vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept && op_clear) begin
      count_r <= '0;
    end else if (accept && op_sample && (count_r < d_use)) begin
      count_r <= count_r + esr_pkg::DCNT_W'(1);
    end else if ((state_r == esr_pkg::ST_EMIT) && last_out) begin
      count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op_sample && (count_r < d_use)) begin
      buf_r[esr_pkg::D_AW'(count_r)] <= in_sample_value;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_r <= esr_pkg::LEAK_W'(65535);
      nreg_r <= esr_pkg::NREG_W'(256);
      dreg_r <= esr_pkg::DREG_W'(16);
      oreg_r <= esr_pkg::OREG_W'(16);
    end else if (cfg_we) begin
      unique case (esr_pkg::cfg_idx_t'(cfg_index))
        esr_pkg::CFG_LEAK:    leak_r <= cfg_data[esr_pkg::LEAK_W-1:0];
        esr_pkg::CFG_NEURONS: nreg_r <= cfg_data[esr_pkg::NREG_W-1:0];
        esr_pkg::CFG_INPUTS:  dreg_r <= cfg_data[esr_pkg::DREG_W-1:0];
        esr_pkg::CFG_OUTPUTS: oreg_r <= cfg_data[esr_pkg::OREG_W-1:0];
        default: ;
      endcase
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= state_r == esr_pkg::ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == esr_pkg::ST_EMIT) begin
      out_index_r <= esr_pkg::OIDX_W'(row_r);
      out_value_r <= esr_pkg::sat_round(acc, esr_pkg::READOUT_SHIFT);
      out_last_r  <= last_out;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_output_index = out_index_r;
  assign out_output_value = out_value_r;
  assign out_last_output  = out_last_r;

  `ESR_ASSERT_IMPL(a_mid_beat_busy, out_valid_r && !out_last_r, state_r != esr_pkg::ST_IDLE, "result beat before the last one found the block idle")
  `ESR_ASSERT_IMPL(a_last_beat_idle, out_valid_r && out_last_r, state_r == esr_pkg::ST_IDLE && count_r == '0, "last result beat without a finished step")
  `ESR_ASSERT_NEXT(a_step_start, accept && op_sample && in_last_element, state_r == esr_pkg::ST_ROW && term_r == '0, "step did not start on a last sample")

endmodule

// ===== bench/tb_echo_state_reservoir_step_checker.sv =====
// ---------------------------------------------------------------------------
// tb_echo_state_reservoir_step_checker
// watches the item, result and register ports of the reservoir step block,
// keeps its own copy of the weights, neuron state and registers, predicts
// every readout beat and compares it field by field in arrival order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_echo_state_reservoir_step_checker
  import esr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [OP_W-1:0]            in_operation,
  input  logic [ROW_W-1:0]           in_row_index,
  input  logic [COL_W-1:0]           in_column_index,
  input  logic signed [DATA_W-1:0]   in_weight_value,
  input  logic signed [DATA_W-1:0]   in_sample_value,
  input  logic                       in_last_element,
  input  logic                       out_valid,
  input  logic [OIDX_W-1:0]          out_output_index,
  input  logic signed [DATA_W-1:0]   out_output_value,
  input  logic                       out_last_output,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         fail_count,
  output int                         pending
);

  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -64'sd140737488355328;

  typedef struct {
    logic [OIDX_W-1:0]        index;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } readout_t;

  logic signed [DATA_W-1:0] res_w   [0:W_DEPTH-1];
  logic signed [DATA_W-1:0] in_w    [0:WIN_DEPTH-1];
  logic signed [DATA_W-1:0] rd_w    [0:WOUT_DEPTH-1];
  logic signed [DATA_W-1:0] x_now   [0:MAX_NEURONS-1];
  logic signed [DATA_W-1:0] x_next  [0:MAX_NEURONS-1];
  logic signed [DATA_W-1:0] u_vec   [0:MAX_INPUTS-1];
  int unsigned              u_count;
  logic [15:0]              leak;
  logic [8:0]               n_reg;
  logic [4:0]               d_reg;
  logic [4:0]               o_reg;
  readout_t                 readout_q [$];

  assign pending = readout_q.size();

  function automatic longint sat_acc(longint a, longint p);
    longint s;
    s = a + p;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic longint round_away(longint v, int sh);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -mag : mag;
  endfunction

  function automatic logic signed [DATA_W-1:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return DATA_W'(v);
  endfunction

  function automatic longint squash(longint acc);
    longint mag;
    longint p;
    longint seg;
    longint lo;
    longint hi;
    longint y;
    mag = acc < 0 ? -acc : acc;
    p = mag >>> 14;
    seg = p >>> 7;
    if (seg >= 32) begin
      y = TANH_PTS[32];
    end else begin
      lo = TANH_PTS[seg];
      hi = TANH_PTS[seg + 1];
      y = lo + (((hi - lo) * (p & 127) + 64) >>> 7);
    end
    return acc < 0 ? -y : y;
  endfunction

  function automatic int unsigned limit_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return v > hi ? hi : v;
  endfunction

  task automatic run_time_step();
    int unsigned n_eff;
    int unsigned d_eff;
    int unsigned o_eff;
    longint acc;
    longint blend;
    readout_t r;
    n_eff = limit_to(n_reg, MAX_NEURONS);
    d_eff = limit_to(d_reg, MAX_INPUTS);
    o_eff = limit_to(o_reg, OUT_LIMIT);
    for (int i = 0; i < n_eff; i++) begin
      acc = longint'(in_w[i*WIN_SPAN]) * 8192;
      for (int j = 0; j < d_eff; j++)
        acc = sat_acc(acc, longint'(in_w[i*WIN_SPAN + 1 + j]) * longint'(u_vec[j]));
      for (int j = 0; j < n_eff; j++)
        acc = sat_acc(acc, longint'(res_w[i*MAX_NEURONS + j]) * longint'(x_now[j]));
      blend = (65536 - longint'(leak)) * longint'(x_now[i])
            + longint'(leak) * squash(acc);
      x_next[i] = clip16(round_away(blend, BLEND_SHIFT));
    end
    for (int i = 0; i < n_eff; i++) x_now[i] = x_next[i];
    for (int k = 0; k < o_eff; k++) begin
      acc = longint'(rd_w[k*ROW_SPAN]) * 8192;
      for (int j = 0; j < d_eff; j++)
        acc = sat_acc(acc, longint'(rd_w[k*ROW_SPAN + 1 + j]) * longint'(u_vec[j]));
      for (int j = 0; j < n_eff; j++)
        acc = sat_acc(acc,
          longint'(rd_w[k*ROW_SPAN + 1 + d_eff + j]) * longint'(x_now[j]));
      r.index = OIDX_W'(k);
      r.value = clip16(round_away(acc, READOUT_SHIFT));
      r.last  = (k + 1 == o_eff);
      readout_q.push_back(r);
    end
    for (int j = 0; j < MAX_INPUTS; j++) u_vec[j] = '0;
    u_count = 0;
  endtask

  task automatic take_item();
    int unsigned row;
    int unsigned col;
    row = in_row_index;
    col = in_column_index;
    case (in_operation)
      OP_WRITE_W: begin
        if (col < MAX_NEURONS) res_w[row*MAX_NEURONS + col] = in_weight_value;
      end
      OP_WRITE_WIN: begin
        if (col < WIN_SPAN) in_w[row*WIN_SPAN + col] = in_weight_value;
      end
      OP_WRITE_WOUT: begin
        if (row < MAX_OUTPUTS && col < ROW_SPAN) rd_w[row*ROW_SPAN + col] = in_weight_value;
      end
      OP_CLEAR: begin
        for (int j = 0; j < MAX_NEURONS; j++) x_now[j] = '0;
        for (int j = 0; j < MAX_INPUTS; j++) u_vec[j] = '0;
        u_count = 0;
      end
      OP_SAMPLE: begin
        if (u_count < limit_to(d_reg, MAX_INPUTS)) begin
          u_vec[u_count] = in_sample_value;
          u_count++;
        end
        if (in_last_element) run_time_step();
      end
      default: ;
    endcase
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    readout_t e;
    if (!rst_n) begin
      for (int j = 0; j < MAX_NEURONS; j++) x_now[j] = '0;
      for (int j = 0; j < MAX_INPUTS; j++) u_vec[j] = '0;
      u_count = 0;
      leak  = 16'd65535;
      n_reg = 9'd256;
      d_reg = 5'd16;
      o_reg = 5'd16;
      readout_q.delete();
    end else begin
      if (out_valid) begin
        if (readout_q.size() == 0) begin
          $error("unexpected readout beat index %0d value %0d",
                 out_output_index, out_output_value);
          fail_count++;
        end else begin
          e = readout_q.pop_front();
          if (out_output_index !== e.index) begin
            $error("output_index expected %0d actual %0d", e.index, out_output_index);
            fail_count++;
          end
          if (out_output_value !== e.value) begin
            $error("output_value expected %0d actual %0d", e.value, out_output_value);
            fail_count++;
          end
          if (out_last_output !== e.last) begin
            $error("last_output expected %0d actual %0d", e.last, out_last_output);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEAK:    leak  = cfg_data[15:0];
          CFG_NEURONS: n_reg = cfg_data[8:0];
          CFG_INPUTS:  d_reg = cfg_data[4:0];
          CFG_OUTPUTS: o_reg = cfg_data[4:0];
          default: ;
        endcase
      end
      if (start && !busy) take_item();
    end
  end

endmodule

// ===== bench/tb_echo_state_reservoir_step.sv =====
// ---------------------------------------------------------------------------
// tb_echo_state_reservoir_step
// stimulus and verdict for the reservoir step block: sets small sizes,
// preloads every weight those sizes read, runs one time step, a directed
// set of edge items, then random weight writes, clears, stray and
// well-formed sample sequences across several register settings, with
// random idle bursts on the item port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_echo_state_reservoir_step;
  import esr_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int STEP_N = 2;
  localparam int STEP_D = 3;
  localparam int STEP_O = 3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [OP_W-1:0]           in_operation = '0;
  logic [ROW_W-1:0]          in_row_index = '0;
  logic [COL_W-1:0]          in_column_index = '0;
  logic signed [DATA_W-1:0]  in_weight_value = '0;
  logic signed [DATA_W-1:0]  in_sample_value = '0;
  logic                      in_last_element = 1'b0;
  logic                      out_valid;
  logic [OIDX_W-1:0]         out_output_index;
  logic signed [DATA_W-1:0]  out_output_value;
  logic                      out_last_output;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  int                        fail_count;
  int                        pending;
  bit                        no_gap = 1'b1;
  int                        idle_cycles = 0;
  int unsigned               d_now = 16;

  echo_state_reservoir_step dut (.*);

  tb_echo_state_reservoir_step_checker checker_i (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_item(op_t op, int unsigned row, int unsigned col,
                           logic [15:0] wv, logic [15:0] sv, bit last);
    start           <= 1'b1;
    in_operation    <= op;
    in_row_index    <= ROW_W'(row);
    in_column_index <= COL_W'(col);
    in_weight_value <= wv;
    in_sample_value <= sv;
    in_last_element <= last;
    do @(posedge clk); while (busy);
    if (!no_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned lk, int unsigned n, int unsigned d, int unsigned o);
    cfg_we <= 1'b1; cfg_index <= CFG_LEAK;    cfg_data <= CFG_W'(lk); @(posedge clk);
    cfg_index <= CFG_NEURONS; cfg_data <= CFG_W'(n); @(posedge clk);
    cfg_index <= CFG_INPUTS;  cfg_data <= CFG_W'(d); @(posedge clk);
    cfg_index <= CFG_OUTPUTS; cfg_data <= CFG_W'(o); @(posedge clk);
    cfg_we <= 1'b0;
    d_now = (d[4:0] == 0) ? 1 : (d[4:0] > MAX_INPUTS ? MAX_INPUTS : d[4:0]);
  endtask

  function automatic logic [15:0] mild_weight();
    return 16'($urandom_range(0, 1023)) - 16'd512;
  endfunction

  task automatic time_step(int unsigned count);
    for (int k = 0; k < count; k++)
      send_item(OP_SAMPLE, $urandom, $urandom, 16'($urandom), 16'($urandom),
                k + 1 == count);
  endtask

  task automatic random_write();
    int unsigned kind;
    op_t op;
    logic [15:0] wv;
    int unsigned row;
    int unsigned col;
    kind = $urandom_range(0, 2);
    op = (kind == 0) ? OP_WRITE_W : (kind == 1) ? OP_WRITE_WIN : OP_WRITE_WOUT;
    wv = ($urandom_range(0, 2) == 0) ? 16'($urandom) : mild_weight();
    row = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
    col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 20);
    send_item(op, row, col, wv, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned lk;
    int unsigned n;
    int unsigned d;
    int unsigned o;
    int unsigned pick;
    int unsigned items;
    int unsigned steps;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small sizes so the preload stays short
    set_regs(65535, STEP_N, STEP_D, STEP_O);

    // preload every weight a step at these sizes reads
    for (int r = 0; r < STEP_N; r++)
      for (int c = 0; c < STEP_N; c++)
        send_item(OP_WRITE_W, r, c, mild_weight(), 16'h0, 1'b0);
    for (int r = 0; r < STEP_N; r++)
      for (int c = 0; c < STEP_D + 1; c++)
        send_item(OP_WRITE_WIN, r, c, mild_weight(), 16'h0, 1'b0);
    for (int r = 0; r < STEP_O; r++)
      for (int c = 0; c < 1 + STEP_D + STEP_N; c++)
        send_item(OP_WRITE_WOUT, r, c, mild_weight(), 16'h0, 1'b0);

    no_gap = 1'b0;
    time_step(STEP_D);
    settle();

    // directed edge items at the smallest sizes
    set_regs(0, 0, 0, 0);
    send_item(OP_WRITE_W, 0, 0, 16'h8000, 16'h0, 1'b0);
    send_item(OP_WRITE_WIN, 0, 0, 16'h7fff, 16'h0, 1'b0);
    send_item(OP_WRITE_WIN, 0, 1, 16'h8000, 16'h0, 1'b0);
    send_item(OP_WRITE_WOUT, 0, 0, 16'h7fff, 16'h0, 1'b0);
    send_item(OP_WRITE_WOUT, 0, 2, 16'h7fff, 16'h0, 1'b0);
    send_item(OP_WRITE_W, 255, 511, 16'h1234, 16'h0, 1'b0);
    send_item(OP_WRITE_WIN, 3, 17, 16'h1234, 16'h0, 1'b0);
    send_item(OP_WRITE_WOUT, 16, 0, 16'h1234, 16'h0, 1'b0);
    send_item(OP_WRITE_WOUT, 0, 273, 16'h1234, 16'h0, 1'b0);
    send_item(op_t'(3'd5), 0, 0, 16'hffff, 16'hffff, 1'b1);
    send_item(op_t'(3'd6), 255, 511, 16'h0, 16'h0, 1'b1);
    send_item(op_t'(3'd7), 0, 0, 16'h0, 16'h0, 1'b1);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h7fff, 1'b1);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h8000, 1'b1);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h8000, 1'b0);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h7fff, 1'b0);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h1111, 1'b1);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h7fff, 1'b0);
    send_item(OP_CLEAR, 0, 0, 16'h0, 16'h0, 1'b0);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h4000, 1'b1);
    settle();
    set_regs(32768, STEP_N, STEP_D, STEP_O);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h7fff, 1'b0);
    send_item(OP_SAMPLE, 0, 0, 16'h0, 16'h8000, 1'b1);
    settle();

    // random phases, the last one without idling
    for (int ph = 0; ph < 3; ph++) begin
      pick = $urandom_range(0, 2);
      lk = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 65535);
      n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, STEP_N);
      d = $urandom_range(0, STEP_D);
      o = $urandom_range(0, STEP_O);
      if (ph == 2) no_gap = 1'b1;
      set_regs(lk, n, d, o);
      items = 0;
      steps = 0;
      while (items < 10 || steps < 3) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          if (pick < 45) d = d_now;
          else if (pick < 55) d = $urandom_range(1, d_now);
          else d = d_now + $urandom_range(1, 3);
          time_step(d);
          items += d;
          steps++;
        end else if (pick < 85) begin
          random_write();
          items++;
        end else if (pick < 90) begin
          send_item(OP_CLEAR, $urandom, $urandom, 16'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)));
          items++;
        end else if (pick < 95) begin
          send_item(OP_SAMPLE, $urandom, $urandom, 16'($urandom), 16'($urandom), 1'b0);
          items++;
        end else begin
          send_item(op_t'($urandom_range(5, 7)), $urandom, $urandom, 16'($urandom),
                    16'($urandom), 1'($urandom_range(0, 1)));
          items++;
        end
      end
      settle();
    end

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/esr_pkg.sv
design/esr_ram.sv
design/esr_cell.sv
design/esr_mac.sv
design/echo_state_reservoir_step.sv
bench/tb_echo_state_reservoir_step_checker.sv
bench/tb_echo_state_reservoir_step.sv
